>>> hw/rtl/nrcc_pkg.sv
package nrcc_pkg;

	// default table geometry
	localparam int NRCC_NUM_COLORS = 12;
	localparam int NRCC_NUM_SIDES  = 2;

	// field widths
	localparam int CHAN_W  = 16;
	localparam int COLOR_W = 4;
	localparam int DIST_W  = 34;
	localparam int SQ_W    = 2 * CHAN_W;
	localparam int ENTRY_W = 3 * CHAN_W;
	localparam int LUMA_W  = 26;

	// stream and register port widths
	localparam int S_TDATA_W = 56;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 56;
	localparam int M_TUSER_W = 1;
	localparam int APB_DATA_W = 64;
	localparam int APB_ADDR_W = 4;

	// luminance weights, result scaled by 1/1024
	localparam int LUMA_R = 218;
	localparam int LUMA_G = 732;
	localparam int LUMA_B = 74;
	localparam int LUMA_SHIFT = 10;

	// register reset values
	localparam logic [DIST_W-1:0]  MATCH_LIMIT_RST = DIST_W'(1000000000);
	localparam logic [COLOR_W-1:0] FALLBACK_RST    = COLOR_W'(11);

	// register indexes
	localparam logic REG_MATCH_LIMIT = 1'b0;
	localparam logic REG_FALLBACK    = 1'b1;

	// request kinds
	localparam logic REQ_STORE    = 1'b0;
	localparam logic REQ_CLASSIFY = 1'b1;

	typedef struct packed {
		logic accept;
		logic scan_en;
		logic load_out;
	} nrcc_cmd_t;

	typedef struct packed {
		logic issue_last;
		logic scan_done;
		logic out_free;
	} nrcc_sts_t;

endpackage

>>> hw/rtl/nrcc_regs.sv
module nrcc_regs
	import nrcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [DIST_W-1:0]     match_limit,
	output logic [COLOR_W-1:0]    fallback_color
);

	logic                wr_en;
	logic                reg_sel;
	logic [DIST_W-1:0]   match_limit_q;
	logic [COLOR_W-1:0]  fallback_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	// registers sit 8 bytes apart
	assign reg_sel = paddr[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_limit_q <= MATCH_LIMIT_RST;
			fallback_q    <= FALLBACK_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_MATCH_LIMIT: match_limit_q <= pwdata[DIST_W-1:0];
				REG_FALLBACK:    fallback_q    <= pwdata[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_MATCH_LIMIT: prdata = {{(APB_DATA_W-DIST_W){1'b0}}, match_limit_q};
			REG_FALLBACK:    prdata = {{(APB_DATA_W-COLOR_W){1'b0}}, fallback_q};
			default:         prdata = '0;
		endcase
	end

	assign match_limit    = match_limit_q;
	assign fallback_color = fallback_q;

endmodule

>>> hw/rtl/nrcc_ctrl.sv
module nrcc_ctrl
	import nrcc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	input  logic      req_type,
	output logic      s_tready,
	input  nrcc_sts_t sts,
	output nrcc_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.scan_en  = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = s_tvalid;
				if (s_tvalid) begin
					state_d = (req_type == REQ_CLASSIFY) ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// wait for the last entry to leave the distance pipeline
				if (sts.scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.load_out = sts.out_free;
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/nrcc_dp.sv
module nrcc_dp
	import nrcc_pkg::*;
#(
	parameter int NUM_COLORS = NRCC_NUM_COLORS,
	parameter int NUM_SIDES  = NRCC_NUM_SIDES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nrcc_cmd_t            cmd,
	output nrcc_sts_t            sts,
	input  logic                 req_type,
	input  logic                 table_side,
	input  logic [COLOR_W-1:0]   color_index,
	input  logic [CHAN_W-1:0]    red,
	input  logic [CHAN_W-1:0]    green,
	input  logic [CHAN_W-1:0]    blue,
	input  logic [DIST_W-1:0]    match_limit,
	input  logic [COLOR_W-1:0]   fallback_color,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [M_TUSER_W-1:0] m_tuser
);

	localparam int CIW   = $clog2(NUM_COLORS);
	localparam int SW    = (NUM_SIDES > 1) ? $clog2(NUM_SIDES) : 1;
	localparam int AW    = SW + CIW;
	localparam int DEPTH = 1 << AW;

	// request held for the whole transaction
	logic                req_q;
	logic [SW-1:0]       side_q;
	logic [COLOR_W-1:0]  idx_q;
	logic [CHAN_W-1:0]   red_q;
	logic [CHAN_W-1:0]   green_q;
	logic [CHAN_W-1:0]   blue_q;

	logic [SW-1:0]       side_sel;
	logic [CIW+3:0]      widx_ext;
	logic [AW-1:0]       waddr;
	logic                store_wr;

	logic [ENTRY_W-1:0]  mem [DEPTH];
	logic [DEPTH-1:0]    written_q;

	logic [CIW-1:0]      cnt_q;
	logic [AW-1:0]       raddr;

	// scan pipeline
	logic                v_s1, v_s2, v_s3;
	logic                last_s1, last_s2, last_s3;
	logic                wr_s1, wr_s2, wr_s3;
	logic [CIW-1:0]      idx_s1, idx_s2, idx_s3;
	logic [ENTRY_W-1:0]  rd_s1;
	logic [CHAN_W-1:0]   ref_r, ref_g, ref_b;
	logic [CHAN_W-1:0]   dr_s2, dg_s2, db_s2;
	logic [SQ_W-1:0]     sqr_s3, sqg_s3, sqb_s3;
	logic [DIST_W-1:0]   dist_sum;

	logic [DIST_W-1:0]   best_q;
	logic [CIW-1:0]      best_idx_q;
	logic                best_wr_q;
	logic [CIW+3:0]      bidx_ext;

	logic [LUMA_W-1:0]   luma_sum;
	logic                out_valid_q;
	logic [COLOR_W-1:0]  out_color_q;
	logic                out_nomatch_q;
	logic [DIST_W-1:0]   out_dist_q;
	logic [CHAN_W-1:0]   out_bright_q;

	// a side beyond the table count maps to the last side
	assign side_sel = (32'(table_side) >= NUM_SIDES) ? SW'(NUM_SIDES - 1) : SW'(table_side);
	assign widx_ext = {{CIW{1'b0}}, color_index};
	assign waddr    = {side_sel, widx_ext[CIW-1:0]};
	assign store_wr = cmd.accept && (req_type == REQ_STORE) && (32'(color_index) < NUM_COLORS);
	assign raddr    = {side_q, cnt_q};

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q   <= req_type;
			side_q  <= side_sel;
			idx_q   <= color_index;
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
		end
	end

	always_ff @(posedge clk) begin
		if (store_wr) begin
			mem[waddr] <= {blue, green, red};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_en) begin
			rd_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			cnt_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
		end else begin
			if (store_wr) begin
				written_q[waddr] <= 1'b1;
			end
			if (cmd.accept) begin
				cnt_q <= '0;
			end else if (cmd.scan_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			v_s1 <= cmd.scan_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// entries never written read as zero
	assign ref_r = wr_s1 ? rd_s1[CHAN_W-1:0]          : '0;
	assign ref_g = wr_s1 ? rd_s1[2*CHAN_W-1:CHAN_W]   : '0;
	assign ref_b = wr_s1 ? rd_s1[3*CHAN_W-1:2*CHAN_W] : '0;

	always_ff @(posedge clk) begin
		idx_s1  <= cnt_q;
		last_s1 <= sts.issue_last;
		wr_s1   <= written_q[raddr];

		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		wr_s2   <= wr_s1;
		dr_s2   <= (red_q   >= ref_r) ? red_q   - ref_r : ref_r - red_q;
		dg_s2   <= (green_q >= ref_g) ? green_q - ref_g : ref_g - green_q;
		db_s2   <= (blue_q  >= ref_b) ? blue_q  - ref_b : ref_b - blue_q;

		idx_s3  <= idx_s2;
		last_s3 <= last_s2;
		wr_s3   <= wr_s2;
		sqr_s3  <= dr_s2 * dr_s2;
		sqg_s3  <= dg_s2 * dg_s2;
		sqb_s3  <= db_s2 * db_s2;
	end

	assign dist_sum = DIST_W'(sqr_s3) + DIST_W'(sqg_s3) + DIST_W'(sqb_s3);

	// strict less-than keeps the lowest index on a tie
	always_ff @(posedge clk) begin
		if (v_s3 && ((idx_s3 == '0) || (dist_sum < best_q))) begin
			best_q     <= dist_sum;
			best_idx_q <= idx_s3;
			best_wr_q  <= wr_s3;
		end
	end

	assign sts.issue_last = (cnt_q == CIW'(NUM_COLORS - 1));
	assign sts.scan_done  = v_s3 && last_s3;
	assign sts.out_free   = !out_valid_q || m_tready;

	assign bidx_ext = {4'b0000, best_idx_q};
	assign luma_sum = LUMA_W'(red_q) * LUMA_W'(LUMA_R) + LUMA_W'(green_q) * LUMA_W'(LUMA_G)
	                + LUMA_W'(blue_q) * LUMA_W'(LUMA_B);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_bright_q <= luma_sum[LUMA_SHIFT+CHAN_W-1:LUMA_SHIFT];
			if (req_q == REQ_STORE) begin
				out_color_q   <= idx_q;
				out_nomatch_q <= 1'b0;
				out_dist_q    <= '0;
			end else if (best_q < match_limit) begin
				out_color_q   <= best_wr_q ? bidx_ext[COLOR_W-1:0] : '0;
				out_nomatch_q <= 1'b0;
				out_dist_q    <= best_q;
			end else begin
				out_color_q   <= fallback_color;
				out_nomatch_q <= 1'b1;
				out_dist_q    <= best_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W-CHAN_W-DIST_W-COLOR_W){1'b0}}, out_bright_q, out_dist_q,
	                   out_color_q};
	assign m_tuser  = out_nomatch_q;

	a_accept_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !(v_s1 || v_s2 || v_s3))
		else $error("item accepted while scan pipeline busy");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_tready))
		else $error("pending result overwritten");

	a_first_entry_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && (idx_s3 == '0)) |=> (best_q == $past(dist_sum)))
		else $error("scan did not restart from first entry");

endmodule

>>> hw/rtl/nearest_reference_color_classifier_top.sv
// nearest reference color classifier
// input stream s_*: one transaction is either a store of a reference rgb entry
// (req_type 0) into the table of one sensor side, or a classify of an rgb
// sample (req_type 1) against all NUM_COLORS entries of that side.
// output stream m_*: exactly one result per input transaction, in order.
// store: after acceptance the control moves to its finish state and loads the
// result into the output register once that is free. classify: the table memory
// is read one entry per cycle through a three-stage distance pipeline; the
// result is loaded once the last entry has left the pipeline and the output
// register is free. one item is in work at a time.
// the result sits in an output register, so a new item is accepted while it
// waits; when the receiver stalls, the block holds its finished result and
// stops at the end of the next item until the register frees up.
// reset clears all table entries to zero (valid bit per entry), match_limit to
// 1000000000 and fallback_color to 11. the user must write the registers over the
// apb port only while the block is idle; the block itself does not enforce this.
module nearest_reference_color_classifier_top
	import nrcc_pkg::*;
#(
	parameter int NUM_COLORS = NRCC_NUM_COLORS,
	parameter int NUM_SIDES  = NRCC_NUM_SIDES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// color_index[3:0], red[19:4], green[35:20], blue[51:36], zero fill
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// req_type[0], sensor_side[1]
	input  logic [S_TUSER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// matched_color[3:0], best_distance[37:4], brightness[53:38], zero fill
	output logic [M_TDATA_W-1:0]  m_tdata,
	// no_match[0]
	output logic [M_TUSER_W-1:0]  m_tuser,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	nrcc_cmd_t          cmd;
	nrcc_sts_t          sts;
	logic [DIST_W-1:0]  match_limit;
	logic [COLOR_W-1:0] fallback_color;

	nrcc_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.match_limit    (match_limit),
		.fallback_color (fallback_color)
	);

	nrcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.req_type (s_tuser[0]),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	nrcc_dp #(
		.NUM_COLORS (NUM_COLORS),
		.NUM_SIDES  (NUM_SIDES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_type       (s_tuser[0]),
		.table_side     (s_tuser[1]),
		.color_index    (s_tdata[3:0]),
		.red            (s_tdata[19:4]),
		.green          (s_tdata[35:20]),
		.blue           (s_tdata[51:36]),
		.match_limit    (match_limit),
		.fallback_color (fallback_color),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser)
	);

endmodule

>>> tb/testbench.sv
module testbench;
	import nrcc_pkg::*;

	localparam int NUM_PHASES     = 7;
	localparam int RAND_PER_PHASE = 118;
	localparam int CYCLE_LIMIT    = 600000;
	localparam int DRAIN_CYCLES   = 24;

	typedef struct {
		logic                req_type;
		logic                side;
		logic [COLOR_W-1:0]  index;
		logic [CHAN_W-1:0]   red;
		logic [CHAN_W-1:0]   green;
		logic [CHAN_W-1:0]   blue;
	} color_req_t;

	typedef struct {
		logic [COLOR_W-1:0]  color;
		logic                no_match;
		logic [DIST_W-1:0]   distance;
		logic [CHAN_W-1:0]   bright;
	} color_res_t;

	typedef struct {
		bit [CHAN_W-1:0] red;
		bit [CHAN_W-1:0] green;
		bit [CHAN_W-1:0] blue;
		bit              stored;
	} rgb_entry_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [S_TUSER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [M_TUSER_W-1:0]  m_tuser;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// shadow of the block state and registers
	rgb_entry_t         palette [NRCC_NUM_SIDES][NRCC_NUM_COLORS];
	logic [DIST_W-1:0]  limit_reg = MATCH_LIMIT_RST;
	logic [COLOR_W-1:0] fallback_reg = FALLBACK_RST;

	color_req_t  req_queue[$];
	color_res_t  expected_results[$];
	color_req_t  drv_item;
	int          src_pct = 0;
	int          snk_pct = 0;
	int          src_wait = 0;
	int          snk_wait = 0;
	int          fail_count = 0;
	int unsigned cycle_count = 0;

	nearest_reference_color_classifier_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #6 clk = ~clk;

	function automatic logic [63:0] chan_sq(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
		logic [CHAN_W-1:0] d;
		d = (a > b) ? a - b : b - a;
		return 64'(d) * 64'(d);
	endfunction

	// updates the shadow table on a store, returns the result the block should give
	function automatic color_res_t apply_request(color_req_t q);
		color_res_t r;
		logic [63:0] d;
		logic [63:0] best;
		int best_i;
		r.bright = 16'((64'(q.red) * LUMA_R + 64'(q.green) * LUMA_G
			+ 64'(q.blue) * LUMA_B) >> LUMA_SHIFT);
		if (q.req_type == REQ_STORE) begin
			if (q.index < NRCC_NUM_COLORS)
				palette[q.side][q.index] = '{q.red, q.green, q.blue, 1'b1};
			r.color = q.index;
			r.no_match = 1'b0;
			r.distance = '0;
			return r;
		end
		best = 0;
		best_i = 0;
		for (int i = 0; i < NRCC_NUM_COLORS; i++) begin
			d = chan_sq(q.red, palette[q.side][i].red) + chan_sq(q.green, palette[q.side][i].green)
				+ chan_sq(q.blue, palette[q.side][i].blue);
			// strict less-than keeps the lowest index on a tie
			if (i == 0 || d < best) begin
				best = d;
				best_i = i;
			end
		end
		if (best < limit_reg) begin
			// a cleared entry reports color 0 whatever its index
			r.color = palette[q.side][best_i].stored ? COLOR_W'(best_i) : '0;
			r.no_match = 1'b0;
		end else begin
			r.color = fallback_reg;
			r.no_match = 1'b1;
		end
		r.distance = best[DIST_W-1:0];
		return r;
	endfunction

	function automatic int idle_len(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CHAN_W-1:0] rand_chan();
		case ($urandom_range(0, 19))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return CHAN_W'($urandom_range(0, 65535));
			end
		endcase
	endfunction

	function automatic logic [CHAN_W-1:0] near_chan(logic [CHAN_W-1:0] c, int span);
		int v;
		v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[CHAN_W-1:0];
	endfunction

	// mostly samples close to stored entries so the limit and tie logic get exercised
	function automatic color_req_t random_request();
		color_req_t q;
		rgb_entry_t e;
		int roll;
		int span;
		roll = $urandom_range(0, 99);
		q.side = 1'($urandom_range(0, 1));
		q.index = COLOR_W'($urandom_range(0, 15));
		q.red = rand_chan();
		q.green = rand_chan();
		q.blue = rand_chan();
		if (roll < 35) begin
			q.req_type = REQ_STORE;
			if ($urandom_range(0, 9) != 0)
				q.index = COLOR_W'($urandom_range(0, NRCC_NUM_COLORS - 1));
			if ($urandom_range(0, 9) == 0) begin
				e = palette[q.side][$urandom_range(0, NRCC_NUM_COLORS - 1)];
				q.red = e.red;
				q.green = e.green;
				q.blue = e.blue;
			end
		end else begin
			q.req_type = REQ_CLASSIFY;
			if (roll < 85) begin
				e = palette[q.side][$urandom_range(0, NRCC_NUM_COLORS - 1)];
				case ($urandom_range(0, 2))
					0: begin
						span = 0;
					end
					1: begin
						span = 255;
					end
					default: begin
						span = 4095;
					end
				endcase
				q.red = near_chan(e.red, span);
				q.green = near_chan(e.green, span);
				q.blue = near_chan(e.blue, span);
			end
		end
		return q;
	endfunction

	task automatic push_req(logic kind, logic side, logic [COLOR_W-1:0] idx,
			logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
		color_req_t q;
		q = '{kind, side, idx, r, g, b};
		req_queue.push_back(q);
	endtask

	task automatic reg_write(logic idx, logic [APB_DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'({idx, 3'b000});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_MATCH_LIMIT)
			limit_reg = value[DIST_W-1:0];
		else
			fallback_reg = value[COLOR_W-1:0];
	endtask

	// sampled at the falling edge so all updates of the rising edge have settled
	task automatic wait_idle();
		do
			@(negedge clk);
		while (req_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
	endtask

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		color_res_t res;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			src_wait = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				res = apply_request(drv_item);
				expected_results.push_back(res);
			end
			if (!s_tvalid || s_tready) begin
				if (src_wait > 0) begin
					src_wait--;
					s_tvalid <= 1'b0;
				end else if (req_queue.size() != 0) begin
					drv_item = req_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, drv_item.blue, drv_item.green, drv_item.red, drv_item.index};
					s_tuser <= {drv_item.side, drv_item.req_type};
					src_wait = idle_len(src_pct);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		color_res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with no request outstanding");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("matched_color", 64'(want.color), 64'(m_tdata[3:0]));
					check_field("no_match", 64'(want.no_match), 64'(m_tuser[0]));
					check_field("best_distance", 64'(want.distance), 64'(m_tdata[37:4]));
					check_field("brightness", 64'(want.bright), 64'(m_tdata[53:38]));
				end
			end
			if (snk_wait > 0) begin
				snk_wait--;
				m_tready <= 1'b0;
			end else begin
				snk_wait = idle_len(snk_pct);
				m_tready <= (snk_wait == 0);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("nearest_reference_color_classifier_top verification failed");
			$finish;
		end
	end

	initial begin
		int src_tab [NUM_PHASES];
		int snk_tab [NUM_PHASES];
		src_tab = '{20, 0, 50, 10, 30, 5, 25};
		snk_tab = '{20, 0, 10, 60, 30, 50, 25};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			src_pct = src_tab[ph];
			snk_pct = snk_tab[ph];
			case (ph)
				0: begin
					// empty tables: a cleared entry wins and reports color 0, or the fallback beyond the limit
					push_req(REQ_CLASSIFY, 1'b0, 4'd0, 16'd0, 16'd0, 16'd0);
					push_req(REQ_CLASSIFY, 1'b1, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
					// two identical entries, lower index must win
					push_req(REQ_STORE, 1'b0, 4'd5, 16'd1000, 16'd2000, 16'd3000);
					push_req(REQ_STORE, 1'b0, 4'd3, 16'd1000, 16'd2000, 16'd3000);
					push_req(REQ_CLASSIFY, 1'b0, 4'd7, 16'd1000, 16'd2000, 16'd3010);
					push_req(REQ_STORE, 1'b1, 4'd11, 16'hFFFF, 16'hFFFF, 16'hFFFF);
					push_req(REQ_CLASSIFY, 1'b1, 4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
					// store index past the table writes nothing
					push_req(REQ_STORE, 1'b1, 4'd15, 16'd123, 16'd456, 16'd789);
					push_req(REQ_STORE, 1'b0, 4'd12, 16'hFFFF, 16'd0, 16'd0);
					push_req(REQ_CLASSIFY, 1'b1, 4'd15, 16'd123, 16'd456, 16'd789);
					push_req(REQ_STORE, 1'b1, 4'd0, 16'd0, 16'd0, 16'd0);
					push_req(REQ_CLASSIFY, 1'b1, 4'd0, 16'd0, 16'd0, 16'd0);
					push_req(REQ_STORE, 1'b0, 4'd0, 16'hFFFF, 16'd0, 16'd0);
					push_req(REQ_STORE, 1'b0, 4'd1, 16'd0, 16'hFFFF, 16'd0);
					push_req(REQ_STORE, 1'b0, 4'd2, 16'd0, 16'd0, 16'hFFFF);
					push_req(REQ_STORE, 1'b0, 4'd11, 16'hFFFF, 16'hFFFF, 16'hFFFF);
					push_req(REQ_CLASSIFY, 1'b0, 4'd9, 16'd40000, 16'd40000, 16'd40000);
					push_req(REQ_CLASSIFY, 1'b0, 4'd3, 16'hFFFF, 16'hFFFF, 16'd0);
					push_req(REQ_STORE, 1'b0, 4'd10, 16'h5555, 16'hAAAA, 16'h5555);
					push_req(REQ_STORE, 1'b1, 4'd10, 16'hAAAA, 16'h5555, 16'hAAAA);
					push_req(REQ_CLASSIFY, 1'b1, 4'd10, 16'hAAAA, 16'h5555, 16'hAAAA);
				end
				1: begin
					// nothing can be below zero; upper write bits are ignored
					reg_write(REG_MATCH_LIMIT, {30'h15555555, 34'd0});
					reg_write(REG_FALLBACK, 64'd0);
				end
				2: begin
					reg_write(REG_MATCH_LIMIT, 64'h3_FFFF_FFFF);
					reg_write(REG_FALLBACK, 64'd15);
				end
				3: begin
					reg_write(REG_MATCH_LIMIT, 64'({2'($urandom_range(0, 3)), 32'($urandom)}));
					reg_write(REG_FALLBACK, 64'($urandom_range(12, 15)));
				end
				4: begin
					// only exact copies match
					reg_write(REG_MATCH_LIMIT, 64'd1);
					reg_write(REG_FALLBACK, 64'($urandom_range(0, 15)));
				end
				5: begin
					reg_write(REG_MATCH_LIMIT, 64'd12884508675);
					reg_write(REG_FALLBACK, 64'hFFFF_FFFF_FFFF_FFF7);
				end
				default: begin
					reg_write(REG_MATCH_LIMIT, 64'd100000);
					reg_write(REG_FALLBACK, 64'd11);
				end
			endcase
			for (int n = 0; n < RAND_PER_PHASE; n++)
				req_queue.push_back(random_request());
		end
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("nearest_reference_color_classifier_top verification clean");
		else
			$display("nearest_reference_color_classifier_top verification failed");
		$finish;
	end

endmodule
